// ===== rtl/weighted_spot_history_map_top_defines.svh =====
// ----------------------------------------------------------------------------
// weighted spot history map assertion macros
// shared assertion wrappers for the history map rtl
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_SPOT_HISTORY_MAP_TOP_DEFINES_SVH
`define WEIGHTED_SPOT_HISTORY_MAP_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WSHM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define WSHM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WSHM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define WSHM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/wshm_pkg.sv =====
// ----------------------------------------------------------------------------
// weighted spot history map package
// codes, widths and defaults shared by the history map rtl
// ----------------------------------------------------------------------------
`default_nettype none

package wshm_pkg;

    localparam int MAX_SPOTS_DEF     = 4096;
    localparam int HISTORY_LIMIT_DEF = 1000000000;

    localparam int WEIGHT_W = 40;
    localparam int SCALE_W  = 32;
    localparam int TOTAL_W  = 30;
    localparam int ROW_W    = 12;
    localparam int ROWS_W   = 13;
    localparam int COUNT_W  = 48;
    localparam int ACC_W    = 72;
    localparam int PROD_W   = 36;
    localparam int CFG_W    = 32;

    localparam logic [ROWS_W-1:0] ROWS_SAT  = '1;
    localparam logic [ACC_W-1:0]  ROUND_ADD = ACC_W'(1) << 23;

    typedef logic [2:0] t_status;
    typedef logic [1:0] t_func;
    typedef logic [1:0] t_cfg_index;

    localparam t_func FN_LOAD  = 2'd0;
    localparam t_func FN_QUERY = 2'd1;
    localparam t_func FN_CLEAR = 2'd2;
    localparam t_func FN_NOP   = 2'd3;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BAD_RANGE = 3'd1;
    localparam t_status ST_NO_HIST   = 3'd2;
    localparam t_status ST_OVER      = 3'd3;
    localparam t_status ST_NOT_READY = 3'd4;

    localparam t_cfg_index CFG_SCALE = 2'd0;
    localparam t_cfg_index CFG_FIRST = 2'd1;
    localparam t_cfg_index CFG_LAST  = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RST = 32'h0001_0000;
    localparam logic [ROW_W-1:0]   FIRST_RST = '0;
    localparam logic [ROWS_W-1:0]  LAST_RST  = '1;

    function automatic t_status cur_status(input logic ready, input t_status err);
        t_status s;
        if (ready) begin
            s = ST_OK;
        end else if (err != ST_OK) begin
            s = err;
        end else begin
            s = ST_NOT_READY;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/weighted_spot_history_map_top.sv =====
// ----------------------------------------------------------------------------
// weighted spot history map
// scaled spot weights to a history start table with binary search lookup
// ----------------------------------------------------------------------------
// One transaction is worked at a time; o_in_ready is high only while idle, and
// a finished result may wait in the output register while the next
// transaction is taken. A load of an in-range row passes the multiply, add and
// final states: a 20x16 multiplier is shared over four partial products, then
// one add and limit compare, then the final checks. A load of a zero weight or
// an out-of-range row goes straight to the final checks; no-ops, clears,
// queries that miss and loads after the plan has finished go to the result.
// A query that hits makes one start-table read per search step through the
// single read port of the table memory. A previous result that still waits for
// i_out_ready holds the new result back. The table needs no clearing pass;
// reset and clear zero the counters and leave the table memory as it is.
`default_nettype none
`include "weighted_spot_history_map_top_defines.svh"

module weighted_spot_history_map_top #(
    parameter int MAX_SPOTS     = wshm_pkg::MAX_SPOTS_DEF,
    parameter int HISTORY_LIMIT = wshm_pkg::HISTORY_LIMIT_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [1:0]                           i_cfg_index,
    input  wire  [wshm_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  [1:0]                           i_func,
    input  wire  [wshm_pkg::WEIGHT_W-1:0]        i_row_weight,
    input  wire                                  i_final_row,
    input  wire  [wshm_pkg::TOTAL_W-1:0]         i_history_index,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic                                 o_found,
    output logic [wshm_pkg::ROW_W-1:0]           o_entry_index,
    output logic [wshm_pkg::ROW_W-1:0]           o_plan_row,
    output logic [2:0]                           o_status,
    output logic [wshm_pkg::TOTAL_W-1:0]         o_total_histories,
    output logic [wshm_pkg::ROWS_W-1:0]          o_entry_total
);

    localparam int KW = $clog2(MAX_SPOTS + 1);
    localparam int AW = $clog2(MAX_SPOTS);
    localparam int MW = wshm_pkg::TOTAL_W + wshm_pkg::ROW_W;
    localparam int TW = wshm_pkg::TOTAL_W;
    localparam int RW = wshm_pkg::ROW_W;
    localparam int SW = wshm_pkg::ROWS_W;
    localparam int SUM_W = wshm_pkg::COUNT_W + 1;

    localparam logic [KW-1:0]    KEPT_MAX = KW'(MAX_SPOTS);
    localparam logic [TW-1:0]    LIMIT    = TW'(HISTORY_LIMIT);
    localparam logic [SUM_W-1:0] LIMIT_X  = SUM_W'(HISTORY_LIMIT);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_ADD    = 3'd2;
    localparam logic [2:0] S_FINAL  = 3'd3;
    localparam logic [2:0] S_SEARCH = 3'd4;
    localparam logic [2:0] S_ROW    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // control and configuration
    logic [2:0]                        r_state, n_state;
    logic [wshm_pkg::SCALE_W-1:0]      r_scale, n_scale;
    logic [RW-1:0]                     r_first, n_first;
    logic [SW-1:0]                     r_last, n_last;
    logic [KW-1:0]                     r_kept, n_kept;
    logic [SW-1:0]                     r_rows, n_rows;
    logic [TW-1:0]                     r_total, n_total;
    logic                              r_ovf, n_ovf;
    logic                              r_ready, n_ready;
    wshm_pkg::t_status                 r_err, n_err;
    logic                              r_out_valid, n_out_valid;

    // working payload
    logic [wshm_pkg::WEIGHT_W-1:0]     r_weight, n_weight;
    logic                              r_final, n_final;
    logic [TW-1:0]                     r_idx, n_idx;
    logic [SW-1:0]                     r_row, n_row;
    logic [wshm_pkg::ACC_W-1:0]        r_acc, n_acc;
    logic [wshm_pkg::PROD_W-1:0]       r_prod, n_prod;
    logic [1:0]                        r_pk, n_pk;
    logic [2:0]                        r_cnt, n_cnt;
    logic [KW-1:0]                     r_lo, n_lo;
    logic [KW-1:0]                     r_hi, n_hi;
    logic                              r_res_found, n_res_found;
    logic [RW-1:0]                     r_res_entry, n_res_entry;
    logic [RW-1:0]                     r_res_row, n_res_row;
    wshm_pkg::t_status                 r_res_status, n_res_status;
    logic                              r_out_found, n_out_found;
    logic [RW-1:0]                     r_out_entry, n_out_entry;
    logic [RW-1:0]                     r_out_row, n_out_row;
    wshm_pkg::t_status                 r_out_status, n_out_status;
    logic [TW-1:0]                     r_out_total, n_out_total;
    logic [SW-1:0]                     r_out_kept, n_out_kept;

    // start table memory
    logic [MW-1:0]                     r_mem [MAX_SPOTS];
    logic [MW-1:0]                     r_rd_data;
    logic [AW-1:0]                     mem_raddr;
    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic [MW-1:0]                     mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_found           = r_out_found;
    assign o_entry_index     = r_out_entry;
    assign o_plan_row        = r_out_row;
    assign o_status          = r_out_status;
    assign o_total_histories = r_out_total;
    assign o_entry_total     = r_out_kept;

    always_comb begin
        logic                        in_range;
        logic [19:0]                 w_sel;
        logic [15:0]                 s_sel;
        logic [5:0]                  sh;
        logic [wshm_pkg::COUNT_W-1:0] count;
        logic [SUM_W-1:0]            sum;
        logic [SW-1:0]               first_x;
        logic [SW-1:0]               last_x;
        wshm_pkg::t_status           chk;
        logic [KW:0]                 mid_sum;
        logic [KW-1:0]               mid;
        logic [KW:0]                 nmid_sum;
        logic [KW-1:0]               span;

        n_state      = r_state;
        n_scale      = r_scale;
        n_first      = r_first;
        n_last       = r_last;
        n_kept       = r_kept;
        n_rows       = r_rows;
        n_total      = r_total;
        n_ovf        = r_ovf;
        n_ready      = r_ready;
        n_err        = r_err;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_weight     = r_weight;
        n_final      = r_final;
        n_idx        = r_idx;
        n_row        = r_row;
        n_acc        = r_acc;
        n_prod       = r_prod;
        n_pk         = r_pk;
        n_cnt        = r_cnt;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_res_found  = r_res_found;
        n_res_entry  = r_res_entry;
        n_res_row    = r_res_row;
        n_res_status = r_res_status;
        n_out_found  = r_out_found;
        n_out_entry  = r_out_entry;
        n_out_row    = r_out_row;
        n_out_status = r_out_status;
        n_out_total  = r_out_total;
        n_out_kept   = r_out_kept;
        mem_raddr    = '0;
        mem_we       = 1'b0;
        mem_waddr    = r_kept[AW-1:0];
        mem_wdata    = {r_total, r_row[RW-1:0]};

        in_range = 1'b0;
        w_sel    = '0;
        s_sel    = '0;
        sh       = '0;
        count    = r_acc[wshm_pkg::ACC_W-1:24];
        sum      = SUM_W'(r_total) + SUM_W'(count);
        first_x  = SW'(r_first);
        last_x   = r_last[SW-1] ? (r_rows - SW'(1)) : r_last;
        chk      = wshm_pkg::ST_OK;
        mid_sum  = (KW+1)'(r_lo) + (KW+1)'(r_hi);
        mid      = mid_sum[KW:1];
        nmid_sum = '0;
        span     = '0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                wshm_pkg::CFG_SCALE: n_scale = i_cfg_data;
                wshm_pkg::CFG_FIRST: n_first = i_cfg_data[RW-1:0];
                wshm_pkg::CFG_LAST:  n_last  = i_cfg_data[SW-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_weight     = i_row_weight;
                    n_final      = i_final_row;
                    n_idx        = i_history_index;
                    n_res_found  = 1'b0;
                    n_res_entry  = '0;
                    n_res_row    = '0;
                    n_res_status = wshm_pkg::cur_status(r_ready, r_err);
                    n_state      = S_DONE;
                    unique case (i_func)
                        wshm_pkg::FN_LOAD: begin
                            if (!r_ready && r_err == wshm_pkg::ST_OK) begin
                                n_state = S_FINAL;
                                if (i_row_weight != '0) begin
                                    n_row  = r_rows;
                                    n_rows = (r_rows == wshm_pkg::ROWS_SAT) ? r_rows
                                                                            : r_rows + SW'(1);
                                    in_range = !r_rows[SW-1] && (r_rows >= first_x) &&
                                               (r_last[SW-1] || r_rows <= r_last);
                                    if (in_range) begin
                                        n_acc   = wshm_pkg::ROUND_ADD;
                                        n_cnt   = '0;
                                        n_state = S_MUL;
                                    end
                                end
                            end
                        end
                        wshm_pkg::FN_QUERY: begin
                            if (r_ready && i_history_index < r_total && r_kept != '0) begin
                                n_lo = '0;
                                n_hi = r_kept;
                                if (r_kept > KW'(1)) begin
                                    mem_raddr = AW'(r_kept >> 1);
                                    n_state   = S_SEARCH;
                                end else begin
                                    mem_raddr = '0;
                                    n_state   = S_ROW;
                                end
                            end
                        end
                        wshm_pkg::FN_CLEAR: begin
                            n_kept       = '0;
                            n_rows       = '0;
                            n_total      = '0;
                            n_ovf        = 1'b0;
                            n_ready      = 1'b0;
                            n_err        = wshm_pkg::ST_OK;
                            n_res_status = wshm_pkg::ST_NOT_READY;
                        end
                        wshm_pkg::FN_NOP: ;
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                // partial products: scale half by weight half, one per cycle
                w_sel = r_cnt[1] ? r_weight[39:20] : r_weight[19:0];
                s_sel = r_cnt[0] ? r_scale[31:16] : r_scale[15:0];
                n_prod = wshm_pkg::PROD_W'(w_sel) * wshm_pkg::PROD_W'(s_sel);
                n_pk   = r_cnt[1:0];
                case (r_pk)
                    2'd0:    sh = 6'd0;
                    2'd1:    sh = 6'd16;
                    2'd2:    sh = 6'd20;
                    default: sh = 6'd36;
                endcase
                if (r_cnt != 3'd0) begin
                    n_acc = r_acc + (wshm_pkg::ACC_W'(r_prod) << sh);
                end
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (count != '0) begin
                    if (r_kept >= KEPT_MAX) begin
                        n_ovf = 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        n_kept = r_kept + KW'(1);
                        if (sum > LIMIT_X) begin
                            n_ovf   = 1'b1;
                            n_total = LIMIT;
                        end else begin
                            n_total = sum[TW-1:0];
                        end
                    end
                end
                n_state = S_FINAL;
            end
            S_FINAL: begin
                if (r_final) begin
                    if (first_x >= r_rows) begin
                        chk = wshm_pkg::ST_BAD_RANGE;
                    end else if (last_x >= r_rows || first_x > last_x) begin
                        chk = wshm_pkg::ST_BAD_RANGE;
                    end else if (r_kept == '0 || r_total == '0) begin
                        chk = wshm_pkg::ST_NO_HIST;
                    end else if (r_ovf) begin
                        chk = wshm_pkg::ST_OVER;
                    end else begin
                        chk = wshm_pkg::ST_OK;
                    end
                    n_err        = chk;
                    n_ready      = (chk == wshm_pkg::ST_OK);
                    n_res_status = chk;
                end else begin
                    n_res_status = wshm_pkg::ST_NOT_READY;
                end
                n_state = S_DONE;
            end
            S_SEARCH: begin
                if (r_rd_data[MW-1:RW] <= r_idx) begin
                    n_lo = mid;
                end else begin
                    n_hi = mid;
                end
                span     = n_hi - n_lo;
                nmid_sum = (KW+1)'(n_lo) + (KW+1)'(n_hi);
                if (span > KW'(1)) begin
                    mem_raddr = nmid_sum[AW:1];
                end else begin
                    mem_raddr = n_lo[AW-1:0];
                    n_state   = S_ROW;
                end
            end
            S_ROW: begin
                n_res_found = 1'b1;
                n_res_entry = RW'(r_lo);
                n_res_row   = r_rd_data[RW-1:0];
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = r_res_found;
                    n_out_entry  = r_res_entry;
                    n_out_row    = r_res_row;
                    n_out_status = r_res_status;
                    n_out_total  = r_total;
                    n_out_kept   = SW'(r_kept);
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scale     <= wshm_pkg::SCALE_RST;
            r_first     <= wshm_pkg::FIRST_RST;
            r_last      <= wshm_pkg::LAST_RST;
            r_kept      <= '0;
            r_rows      <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_ready     <= 1'b0;
            r_err       <= wshm_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scale     <= n_scale;
            r_first     <= n_first;
            r_last      <= n_last;
            r_kept      <= n_kept;
            r_rows      <= n_rows;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_ready     <= n_ready;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_weight     <= n_weight;
        r_final      <= n_final;
        r_idx        <= n_idx;
        r_row        <= n_row;
        r_acc        <= n_acc;
        r_prod       <= n_prod;
        r_pk         <= n_pk;
        r_cnt        <= n_cnt;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_res_found  <= n_res_found;
        r_res_entry  <= n_res_entry;
        r_res_row    <= n_res_row;
        r_res_status <= n_res_status;
        r_out_found  <= n_out_found;
        r_out_entry  <= n_out_entry;
        r_out_row    <= n_out_row;
        r_out_status <= n_out_status;
        r_out_total  <= n_out_total;
        r_out_kept   <= n_out_kept;
    end

    // checks
    `WSHM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state != S_IDLE, "accepted transaction left the sequencer idle")
    `WSHM_ASSERT_IMP(a_kept_bound, i_clk, i_rst_n, 1'b1, r_kept <= KEPT_MAX,
        "kept entry count past capacity")
    `WSHM_ASSERT_IMP(a_ready_no_err, i_clk, i_rst_n, r_ready, r_err == wshm_pkg::ST_OK,
        "table ready while an error is held")
    `WSHM_ASSERT_IMP(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= LIMIT,
        "running total past the history limit")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// weighted spot history map testbench
// drives spot plans and history lookups through the handshake ports and
// register settings through the config port, predicts every answer in a
// behavioral table model and compares each returned transaction field by
// field, with random idling on both sides
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        wshm_pkg::t_func func;
        logic [39:0]     weight;
        logic            plan_end;
        logic [29:0]     hidx;
    } t_spot_req;

    typedef struct packed {
        logic              found;
        logic [11:0]       entry;
        logic [11:0]       prow;
        wshm_pkg::t_status status;
        logic [29:0]       total;
        logic [12:0]       entries;
    } t_spot_ans;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 cfg_we     = 1'b0;
    wshm_pkg::t_cfg_index cfg_index  = wshm_pkg::CFG_SCALE;
    logic [31:0]          cfg_data   = '0;
    logic                 send_valid = 1'b0;
    t_spot_req            held_req   = '0;
    logic                 take_ready = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_found;
    logic [11:0] o_entry_index;
    logic [11:0] o_plan_row;
    logic [2:0]  o_status;
    logic [29:0] o_total_histories;
    logic [12:0] o_entry_total;

    t_spot_req plan_queue[$];
    t_spot_ans answer_queue[$];
    int        pushed_count   = 0;
    int        accepted_count = 0;
    int        checked_count  = 0;
    int        mismatch_count = 0;
    int        hit_count      = 0;
    int        plans_run      = 0;
    int        verdict_tally [0:3] = '{0, 0, 0, 0};
    int        send_odds = 0;
    int        take_odds = 0;
    int        send_gap  = 0;
    int        take_gap  = 0;

    // table model
    logic [31:0]       tab_scale;
    int                tab_first;
    int                tab_last;
    logic [29:0]       tab_start [0:4095];
    logic [11:0]       tab_row [0:4095];
    int                tab_kept;
    int                tab_seen;
    int                tab_total;
    bit                tab_over;
    bit                tab_ready;
    wshm_pkg::t_status tab_err;

    weighted_spot_history_map_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (send_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (held_req.func),
        .i_row_weight      (held_req.weight),
        .i_final_row       (held_req.plan_end),
        .i_history_index   (held_req.hidx),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (take_ready),
        .o_found           (o_found),
        .o_entry_index     (o_entry_index),
        .o_plan_row        (o_plan_row),
        .o_status          (o_status),
        .o_total_histories (o_total_histories),
        .o_entry_total     (o_entry_total)
    );

    always #4 i_clk = ~i_clk;

    function automatic void clear_table();
        tab_kept  = 0;
        tab_seen  = 0;
        tab_total = 0;
        tab_over  = 1'b0;
        tab_ready = 1'b0;
        tab_err   = wshm_pkg::ST_OK;
    endfunction

    function automatic wshm_pkg::t_status table_status();
        if (tab_ready) return wshm_pkg::ST_OK;
        if (tab_err != wshm_pkg::ST_OK) return tab_err;
        return wshm_pkg::ST_NOT_READY;
    endfunction

    function automatic void take_plan_row(input logic [39:0] w);
        int               row;
        logic [71:0]      prod;
        longint unsigned  cnt;
        if (w == 0) return;
        row = tab_seen;
        if (tab_seen < 8191) tab_seen++;
        if (row > 4095 || row < tab_first) return;
        if (tab_last >= 0 && row > tab_last) return;
        prod = 72'(w) * 72'(tab_scale) + (72'd1 << 23);
        cnt  = 64'(prod >> 24);
        if (cnt == 0) return;
        if (tab_kept >= wshm_pkg::MAX_SPOTS_DEF) begin
            tab_over = 1'b1;
            return;
        end
        tab_start[tab_kept] = 30'(tab_total);
        tab_row[tab_kept]   = 12'(row);
        tab_kept++;
        if (cnt > longint'(wshm_pkg::HISTORY_LIMIT_DEF - tab_total)) begin
            tab_over  = 1'b1;
            tab_total = wshm_pkg::HISTORY_LIMIT_DEF;
        end else begin
            tab_total += int'(cnt);
        end
    endfunction

    function automatic wshm_pkg::t_status plan_verdict();
        int last_idx;
        if (tab_first >= tab_seen) return wshm_pkg::ST_BAD_RANGE;
        last_idx = (tab_last < 0) ? tab_seen - 1 : tab_last;
        if (last_idx >= tab_seen || tab_first > last_idx) return wshm_pkg::ST_BAD_RANGE;
        if (tab_kept == 0 || tab_total == 0) return wshm_pkg::ST_NO_HIST;
        if (tab_over) return wshm_pkg::ST_OVER;
        return wshm_pkg::ST_OK;
    endfunction

    function automatic t_spot_ans spot_map_answer(input t_spot_req r);
        t_spot_ans a;
        int        lo;
        int        hi;
        int        mid;
        a = '0;
        case (r.func)
            wshm_pkg::FN_LOAD: begin
                if (tab_ready || tab_err != wshm_pkg::ST_OK) begin
                    a.status = table_status();
                end else begin
                    take_plan_row(r.weight);
                    if (r.plan_end) begin
                        a.status  = plan_verdict();
                        tab_err   = a.status;
                        tab_ready = (a.status == wshm_pkg::ST_OK);
                        verdict_tally[a.status]++;
                    end else begin
                        a.status = wshm_pkg::ST_NOT_READY;
                    end
                end
            end
            wshm_pkg::FN_QUERY: begin
                a.status = table_status();
                if (tab_ready && r.hidx < tab_total && tab_kept > 0) begin
                    lo = 0;
                    hi = tab_kept;
                    while (hi - lo > 1) begin
                        mid = (lo + hi) / 2;
                        if (tab_start[mid] <= r.hidx) lo = mid;
                        else hi = mid;
                    end
                    a.found = 1'b1;
                    a.entry = lo[11:0];
                    a.prow  = tab_row[lo];
                end
            end
            wshm_pkg::FN_CLEAR: begin
                clear_table();
                a.status = wshm_pkg::ST_NOT_READY;
            end
            default: begin
                a.status = table_status();
            end
        endcase
        a.total   = 30'(tab_total);
        a.entries = 13'(tab_kept);
        return a;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            send_valid <= 1'b0;
            send_gap   <= 0;
        end else if (!send_valid || o_in_ready) begin
            if (send_valid) begin
                answer_queue.insert(answer_queue.size(), spot_map_answer(held_req));
                accepted_count++;
            end
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                send_valid <= 1'b0;
            end else if (send_odds > 0 && $urandom_range(1, 100) <= send_odds) begin
                send_gap   <= $urandom_range(0, 13);
                send_valid <= 1'b0;
            end else if (plan_queue.size() > 0) begin
                held_req   <= plan_queue.pop_front();
                send_valid <= 1'b1;
            end else begin
                send_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : take_side
        t_spot_ans seen;
        t_spot_ans want;
        if (!i_rst_n) begin
            take_ready <= 1'b0;
            take_gap   <= 0;
        end else begin
            if (o_out_valid && take_ready) begin
                seen = {o_found, o_entry_index, o_plan_row, o_status,
                        o_total_histories, o_entry_total};
                if (answer_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no transaction pending: %p", $realtime, seen);
                end else begin
                    want = answer_queue.pop_front();
                    checked_count++;
                    if (want.found) hit_count++;
                    if (seen.found !== want.found || seen.entry !== want.entry ||
                        seen.prow !== want.prow || seen.status !== want.status ||
                        seen.total !== want.total || seen.entries !== want.entries) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("%0t: mismatch (exp/act) found %0d/%0d entry %0d/%0d",
                                   $realtime, want.found, seen.found, want.entry,
                                   seen.entry);
                            $display(" row %0d/%0d status %0d/%0d total %0d/%0d",
                                     want.prow, seen.prow, want.status, seen.status,
                                     want.total, seen.total);
                            $display("    entries %0d/%0d", want.entries, seen.entries);
                        end
                    end
                end
            end
            if (take_gap > 0) begin
                take_gap   <= take_gap - 1;
                take_ready <= 1'b0;
            end else if (take_odds > 0 && $urandom_range(1, 100) <= take_odds) begin
                take_gap   <= $urandom_range(0, 13);
                take_ready <= 1'b0;
            end else begin
                take_ready <= 1'b1;
            end
        end
    end

    function automatic void push_req(input wshm_pkg::t_func f, input logic [39:0] w,
                                     input logic e, input logic [29:0] h);
        t_spot_req r;
        r.func     = f;
        r.weight   = w;
        r.plan_end = e;
        r.hidx     = h;
        plan_queue.insert(plan_queue.size(), r);
        pushed_count++;
    endfunction

    function automatic void push_load(input logic [39:0] w, input logic e);
        push_req(wshm_pkg::FN_LOAD, w, e, 30'($urandom));
    endfunction

    function automatic void push_query(input logic [29:0] h);
        logic [39:0] w;
        w = 40'({$urandom, $urandom});
        push_req(wshm_pkg::FN_QUERY, w, 1'($urandom), h);
    endfunction

    function automatic void push_other(input wshm_pkg::t_func f);
        logic [39:0] w;
        w = 40'({$urandom, $urandom});
        push_req(f, w, 1'($urandom), 30'($urandom));
    endfunction

    task automatic wait_accepted();
        while (accepted_count != pushed_count) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (accepted_count != pushed_count || answer_queue.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [31:0] scale, input int first, input int last_lim);
        logic [12:0] last_bits;
        last_bits = 13'(last_lim);
        wait_drained();
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= wshm_pkg::CFG_SCALE;
        cfg_data  <= scale;
        @(posedge i_clk);
        cfg_index <= wshm_pkg::CFG_FIRST;
        cfg_data  <= 32'(first);
        @(posedge i_clk);
        cfg_index <= wshm_pkg::CFG_LAST;
        cfg_data  <= 32'(last_lim);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        tab_scale = scale;
        tab_first = first & 4095;
        tab_last  = int'($signed(last_bits));
    endtask

    function automatic logic [39:0] pick_weight();
        logic [39:0] w;
        w = 40'({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0:       w = '0;
            1, 2:    w = 40'($urandom_range(1, 1023));
            3, 4, 5,
            6:       w = 40'($urandom_range(1024, 32'h00FF_FFFF));
            7:       w = 40'($urandom);
            8:       w = w;
            default: w = $urandom_range(0, 1) ? 40'hFF_FFFF_FFFF : 40'd1;
        endcase
        return w;
    endfunction

    function automatic logic [29:0] pick_index();
        int unsigned k;
        logic [29:0] h;
        k = $urandom_range(0, 9);
        h = 30'($urandom);
        if (tab_total > 0 && k < 5)
            h = 30'($urandom_range(0, tab_total - 1));
        else if (tab_kept > 0 && k < 8)
            h = tab_start[$urandom_range(0, tab_kept - 1)] + 30'($urandom_range(0, 2)) - 30'd1;
        else if (k == 8)
            h = 30'(tab_total);
        return h;
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 5;
            default: return 25;
        endcase
    endfunction

    task automatic random_regs();
        logic [31:0] scale;
        int          first;
        int          last_lim;
        case ($urandom_range(0, 7))
            0:       scale = '0;
            1:       scale = '1;
            2, 3:    scale = wshm_pkg::SCALE_RST;
            4:       scale = $urandom_range(1, 32'h0002_0000);
            5:       scale = $urandom;
            default: scale = $urandom_range(32'h100, 32'h1000);
        endcase
        case ($urandom_range(0, 7))
            5:       first = $urandom_range(1, 8);
            6:       first = 4095;
            7:       first = $urandom_range(0, 4095);
            default: first = 0;
        endcase
        case ($urandom_range(0, 7))
            4:       last_lim = $urandom_range(0, 30);
            5:       last_lim = 4095;
            6:       last_lim = -int'($urandom_range(2, 4096));
            7:       last_lim = $urandom_range(0, 4095);
            default: last_lim = -1;
        endcase
        set_regs(scale, first, last_lim);
    endtask

    task automatic random_plan();
        int rows;
        bit drop_final;
        if ($urandom_range(0, 3) == 0) random_regs();
        send_odds = pick_odds();
        take_odds = pick_odds();
        if ($urandom_range(0, 9) != 0) push_other(wshm_pkg::FN_CLEAR);
        rows = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        drop_final = ($urandom_range(0, 19) == 0);
        for (int i = 0; i < rows; i++) begin
            if ($urandom_range(0, 9) == 0)
                push_other($urandom_range(0, 1) ? wshm_pkg::FN_QUERY : wshm_pkg::FN_NOP);
            push_load(pick_weight(), (i == rows - 1) && !drop_final);
            if ($urandom_range(0, 199) == 0) push_other(wshm_pkg::FN_CLEAR);
        end
        wait_accepted();
        repeat ($urandom_range(2, 14)) push_query(pick_index());
        if ($urandom_range(0, 4) == 0) push_load(pick_weight(), 1'b1);
        plans_run++;
    endtask

    initial begin : stimulus
        int base;
        tab_scale = wshm_pkg::SCALE_RST;
        tab_first = 0;
        tab_last  = -1;
        clear_table();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default registers
        push_query(30'd0);
        push_other(wshm_pkg::FN_NOP);
        push_load(40'd0, 1'b0);
        push_load(40'd256, 1'b0);
        push_load(40'd128, 1'b0);
        push_load(40'd127, 1'b0);
        push_load(40'd256000, 1'b0);
        push_load(40'd512, 1'b1);
        push_query(30'd0);
        push_query(30'd1);
        push_query(30'd2);
        push_query(30'd1001);
        push_query(30'd1002);
        push_query(30'd1003);
        push_query(30'd1004);
        push_query(30'h3FFF_FFFF);
        push_load(40'hFF_FFFF_FFFF, 1'b0);
        push_other(wshm_pkg::FN_CLEAR);
        push_load(40'hFF_FFFF_FFFF, 1'b0);
        push_load(40'hFF_FFFF_FFFF, 1'b1);
        push_query(30'd5);
        push_other(wshm_pkg::FN_CLEAR);
        push_load(40'd0, 1'b1);
        push_other(wshm_pkg::FN_CLEAR);
        push_load(40'd1, 1'b1);
        push_other(wshm_pkg::FN_NOP);
        set_regs('0, 4095, 4095);
        push_other(wshm_pkg::FN_CLEAR);
        push_load(40'hFF_FFFF_FFFF, 1'b1);
        set_regs('1, 0, 0);
        push_other(wshm_pkg::FN_CLEAR);
        push_load(40'hFF_FFFF_FFFF, 1'b1);
        push_query(30'd0);

        // random plans
        base = pushed_count;
        while (pushed_count - base < 1700) random_plan();

        // closing plan, no idling from here on
        wait_drained();
        send_odds = 0;
        take_odds = 0;
        set_regs(wshm_pkg::SCALE_RST, 0, -1);
        push_other(wshm_pkg::FN_CLEAR);
        for (int i = 0; i < 150; i++)
            push_load(40'($urandom_range(1, 32'h00FF_FFFF)), i == 149);
        wait_accepted();
        repeat (40) push_query(pick_index());

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("checked %0d transactions over %0d random plans, %0d lookups hit an entry",
                 checked_count, plans_run, hit_count);
        $display("plan endings: ready %0d, bad range %0d, no histories %0d, over limit %0d",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3]);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
